FILE: sv/ssbf_pkg.sv
package ssbf_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int DATA_W         = 8;
    localparam int TRAIL_W        = 8;
    localparam int FREE_W         = 7;

    localparam logic [TRAIL_W-1:0] TRAIL_RESET = 8'd16;

    typedef enum logic [1:0] {
        OP_XFER = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic rx_write;
        logic rx_pop;
        logic tx_write;
        logic tx_pop;
        logic load_result;
    } ssbf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic store_ok;
        logic tx_nonempty;
        logic rx_nonempty;
    } ssbf_status_t;

endpackage

FILE: sv/ssbf_ctrl.sv
module ssbf_ctrl
    import ssbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ssbf_status_t status,
    output ssbf_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   exec;

    assign exec = (state_reg == S_EXEC);
    assign busy = busy_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = start && !busy_reg;
        cmd.load_result = exec;
        case (status.op)
            OP_XFER:
            begin
                cmd.rx_write = exec && status.store_ok;
                cmd.tx_pop   = exec && status.tx_nonempty;
            end
            OP_PUSH: cmd.tx_write = exec;
            OP_POP:  cmd.rx_pop   = exec && status.rx_nonempty;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_one_exec_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one execute cycle");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not enter execute");
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle produced no result strobe");
    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.tx_write && cmd.tx_pop) && !(cmd.rx_write && cmd.rx_pop))
        else $error("ring written and read in the same step");
`endif

endmodule

FILE: sv/ssbf_datapath.sv
module ssbf_datapath
    import ssbf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssbf_cmd_t          cmd,
    output ssbf_status_t       status,
    input  logic [1:0]         operation,
    input  logic [DATA_W-1:0]  data_byte,
    input  logic               cfg_we,
    input  logic [TRAIL_W-1:0] cfg_data,
    output logic [DATA_W-1:0]  reply_byte,
    output logic               rx_stored,
    output logic               wake,
    output logic [DATA_W-1:0]  popped_byte,
    output logic               popped_valid,
    output logic [FREE_W-1:0]  tx_free
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = (PW + 1 > FREE_W) ? PW + 1 : FREE_W;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
        return (i == PW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    logic [DATA_W-1:0] tx_mem [RING_DEPTH];
    logic [DATA_W-1:0] rx_mem [RING_DEPTH];

    logic [PW-1:0]      tx_head_reg, tx_head_next;
    logic [PW-1:0]      tx_tail_reg, tx_tail_next;
    logic [PW-1:0]      rx_head_reg, rx_head_next;
    logic [PW-1:0]      rx_tail_reg, rx_tail_next;
    logic [TRAIL_W-1:0] trail_left_reg, trail_left_next;
    logic [TRAIL_W-1:0] trail_window_reg;

    op_t               op_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] tx_rd_reg;
    logic [DATA_W-1:0] rx_rd_reg;

    logic [DATA_W-1:0] reply_reg;
    logic              stored_reg;
    logic [DATA_W-1:0] popped_reg;
    logic              popped_valid_reg;
    logic [FREE_W-1:0] tx_free_reg;

    logic [CW-1:0] used;
    logic [CW-1:0] space;

    assign status.op          = op_reg;
    assign status.store_ok    = (data_reg != '0) || (trail_left_reg != '0);
    assign status.tx_nonempty = (tx_head_reg != tx_tail_reg);
    assign status.rx_nonempty = (rx_head_reg != rx_tail_reg);

    always_comb
    begin
        tx_head_next    = cmd.tx_write ? ring_next(tx_head_reg) : tx_head_reg;
        tx_tail_next    = cmd.tx_pop   ? ring_next(tx_tail_reg) : tx_tail_reg;
        rx_head_next    = cmd.rx_write ? ring_next(rx_head_reg) : rx_head_reg;
        rx_tail_next    = cmd.rx_pop   ? ring_next(rx_tail_reg) : rx_tail_reg;
        trail_left_next = trail_left_reg;
        if (cmd.rx_write)
        begin
            // nonzero reloads the window, a stored zero uses one count
            trail_left_next = (data_reg != '0) ? trail_window_reg
                                               : trail_left_reg - 1'b1;
        end
        if (tx_head_next >= tx_tail_next)
            used = CW'(tx_head_next) - CW'(tx_tail_next);
        else
            used = CW'(tx_head_next) + CW'(RING_DEPTH) - CW'(tx_tail_next);
        space = CW'(RING_DEPTH - 1) - used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            trail_left_reg   <= '0;
            trail_window_reg <= TRAIL_RESET;
        end
        else
        begin
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            trail_left_reg <= trail_left_next;
            if (cfg_we)
                trail_window_reg <= cfg_data;
        end
    end

    // ring storage: write at head during execute, read tail on accept
    always_ff @(posedge clk)
    begin
        if (cmd.tx_write)
            tx_mem[tx_head_reg] <= data_reg;
        if (cmd.rx_write)
            rx_mem[rx_head_reg] <= data_reg;
        if (cmd.capture)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
            rx_rd_reg <= rx_mem[rx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(operation);
            data_reg <= data_byte;
        end
        if (cmd.load_result)
        begin
            reply_reg        <= cmd.tx_pop ? tx_rd_reg : '0;
            stored_reg       <= cmd.rx_write;
            popped_reg       <= cmd.rx_pop ? rx_rd_reg : '0;
            popped_valid_reg <= cmd.rx_pop;
            tx_free_reg      <= space[FREE_W-1:0];
        end
    end

    assign reply_byte   = reply_reg;
    assign rx_stored    = stored_reg;
    assign wake         = stored_reg;
    assign popped_byte  = popped_reg;
    assign popped_valid = popped_valid_reg;
    assign tx_free      = tx_free_reg;

endmodule

FILE: sv/spi_slave_byte_fifos_unit.sv
// Channel    | Signals                                        | Handshake
// -----------+------------------------------------------------+---------------------------
// command in | start, busy, operation, data_byte              | taken when start && !busy
// result out | done, reply_byte, rx_stored, wake,             | one-cycle strobe on done
//            | popped_byte, popped_valid, tx_free             |
// config     | cfg_valid, cfg_ready, cfg_data                 | write when valid && ready
//
// Each command has an accept and an execute step: the accept edge registers it and
// reads both ring tails, the execute edge updates rings and pointers and loads the
// result, which shows on done in the next cycle while the next command can already be
// taken. The ring memories read synchronously. Reset (rst_n low, asynchronous)
// clears pointers, trailing counter and window register (to 16), not ring contents.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module spi_slave_byte_fifos_unit
    import ssbf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command beat
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [DATA_W-1:0]  data_byte,
    // result beat
    output logic               done,
    output logic [DATA_W-1:0]  reply_byte,
    output logic               rx_stored,
    output logic               wake,
    output logic [DATA_W-1:0]  popped_byte,
    output logic               popped_valid,
    output logic [FREE_W-1:0]  tx_free,
    // trailing window register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TRAIL_W-1:0] cfg_data
);

    ssbf_cmd_t    cmd;
    ssbf_status_t status;

    // The window register is a plain flop: take a write beat at any time.
    assign cfg_ready = 1'b1;

    // Sequence each command: accept, execute, strobe the result.
    ssbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the rings, their pointers, the trailing counter and the result.
    ssbf_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .data_byte    (data_byte),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .reply_byte   (reply_byte),
        .rx_stored    (rx_stored),
        .wake         (wake),
        .popped_byte  (popped_byte),
        .popped_valid (popped_valid),
        .tx_free      (tx_free)
    );

endmodule
